>>> rtl/core/qvr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qvr_pkg
// Types, widths and rounding helpers shared by the quaternion rotation core.
// ----------------------------------------------------------------------------
package qvr_pkg;

  localparam int unsigned FRAC_BITS = 14;
  localparam int unsigned DATA_W    = 16;

  // first product: q * (0,v), three terms per component
  localparam int unsigned P1_W = 2 * DATA_W;
  localparam int unsigned S1_W = P1_W + 2;
  localparam int unsigned T_W  = S1_W + 1 - FRAC_BITS;

  // second product: t * conj(q), four terms per component
  localparam int unsigned P2_W = T_W + DATA_W;
  localparam int unsigned S2_W = P2_W + 2;
  localparam int unsigned R_W  = S2_W + 1 - FRAC_BITS;

  localparam logic signed [S1_W:0] RND1 = (S1_W + 1)'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [S2_W:0] RND2 = (S2_W + 1)'(1) <<< (FRAC_BITS - 1);

  localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W - 1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W - 1){1'b0}}};

  typedef struct packed {
    logic signed [DATA_W-1:0] vec_x;
    logic signed [DATA_W-1:0] vec_y;
    logic signed [DATA_W-1:0] vec_z;
    logic signed [DATA_W-1:0] quat_w;
    logic signed [DATA_W-1:0] quat_x;
    logic signed [DATA_W-1:0] quat_y;
    logic signed [DATA_W-1:0] quat_z;
  } qvr_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] rot_x;
    logic signed [DATA_W-1:0] rot_y;
    logic signed [DATA_W-1:0] rot_z;
    logic                     clipped;
  } qvr_out_t;

  // intermediate quaternion t plus the rotation quaternion it still needs
  typedef struct packed {
    logic                     valid;
    logic signed [T_W-1:0]    t_w;
    logic signed [T_W-1:0]    t_x;
    logic signed [T_W-1:0]    t_y;
    logic signed [T_W-1:0]    t_z;
    logic signed [DATA_W-1:0] q_w;
    logic signed [DATA_W-1:0] q_x;
    logic signed [DATA_W-1:0] q_y;
    logic signed [DATA_W-1:0] q_z;
  } qvr_mid_t;

  typedef struct packed {
    logic                  valid;
    logic signed [R_W-1:0] r_x;
    logic signed [R_W-1:0] r_y;
    logic signed [R_W-1:0] r_z;
  } qvr_rot_t;

  // add half an lsb and shift right with floor
  function automatic logic signed [T_W-1:0] round_shift1(logic signed [S1_W-1:0] x);
    logic signed [S1_W:0] y;
    y = (S1_W + 1)'(x) + RND1;
    return y[S1_W:FRAC_BITS];
  endfunction

  function automatic logic signed [R_W-1:0] round_shift2(logic signed [S2_W-1:0] x);
    logic signed [S2_W:0] y;
    y = (S2_W + 1)'(x) + RND2;
    return y[S2_W:FRAC_BITS];
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/qvr_left.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qvr_left
// Left product t = q * (0,v): a multiply stage then a sum and round stage.
// ----------------------------------------------------------------------------
module qvr_left import qvr_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     valid_i,
  input  wire qvr_in_t  data_i,
  output qvr_mid_t      mid_o
);

  logic signed [P1_W-1:0]   prod_q [12];
  logic signed [DATA_W-1:0] qw_q, qx_q, qy_q, qz_q;
  logic                     valid_a_q;
  qvr_mid_t                 mid_d, mid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
    end else begin
      valid_a_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q[0]  <= data_i.quat_x * data_i.vec_x;
    prod_q[1]  <= data_i.quat_y * data_i.vec_y;
    prod_q[2]  <= data_i.quat_z * data_i.vec_z;
    prod_q[3]  <= data_i.quat_w * data_i.vec_x;
    prod_q[4]  <= data_i.quat_y * data_i.vec_z;
    prod_q[5]  <= data_i.quat_z * data_i.vec_y;
    prod_q[6]  <= data_i.quat_w * data_i.vec_y;
    prod_q[7]  <= data_i.quat_x * data_i.vec_z;
    prod_q[8]  <= data_i.quat_z * data_i.vec_x;
    prod_q[9]  <= data_i.quat_w * data_i.vec_z;
    prod_q[10] <= data_i.quat_x * data_i.vec_y;
    prod_q[11] <= data_i.quat_y * data_i.vec_x;
    qw_q       <= data_i.quat_w;
    qx_q       <= data_i.quat_x;
    qy_q       <= data_i.quat_y;
    qz_q       <= data_i.quat_z;
  end

  always_comb begin
    logic signed [S1_W-1:0] sw, sx, sy, sz;
    sw = -S1_W'(prod_q[0]) - S1_W'(prod_q[1]) - S1_W'(prod_q[2]);
    sx =  S1_W'(prod_q[3]) + S1_W'(prod_q[4]) - S1_W'(prod_q[5]);
    sy =  S1_W'(prod_q[6]) - S1_W'(prod_q[7]) + S1_W'(prod_q[8]);
    sz =  S1_W'(prod_q[9]) + S1_W'(prod_q[10]) - S1_W'(prod_q[11]);
    mid_d.valid = valid_a_q;
    mid_d.t_w   = round_shift1(sw);
    mid_d.t_x   = round_shift1(sx);
    mid_d.t_y   = round_shift1(sy);
    mid_d.t_z   = round_shift1(sz);
    mid_d.q_w   = qw_q;
    mid_d.q_x   = qx_q;
    mid_d.q_y   = qy_q;
    mid_d.q_z   = qz_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q <= '0;
    end else begin
      mid_q <= mid_d;
    end
  end

  assign mid_o = mid_q;

endmodule
`default_nettype wire

>>> rtl/core/qvr_right.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qvr_right
// Right product r = t * conj(q), vector part: multiply stage then sum and round.
// ----------------------------------------------------------------------------
module qvr_right import qvr_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire qvr_mid_t mid_i,
  output qvr_rot_t      rot_o
);

  logic signed [P2_W-1:0] prod_q [12];
  logic                   valid_c_q;
  qvr_rot_t               rot_d, rot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_c_q <= 1'b0;
    end else begin
      valid_c_q <= mid_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q[0]  <= mid_i.t_w * mid_i.q_x;
    prod_q[1]  <= mid_i.t_x * mid_i.q_w;
    prod_q[2]  <= mid_i.t_y * mid_i.q_z;
    prod_q[3]  <= mid_i.t_z * mid_i.q_y;
    prod_q[4]  <= mid_i.t_w * mid_i.q_y;
    prod_q[5]  <= mid_i.t_x * mid_i.q_z;
    prod_q[6]  <= mid_i.t_y * mid_i.q_w;
    prod_q[7]  <= mid_i.t_z * mid_i.q_x;
    prod_q[8]  <= mid_i.t_w * mid_i.q_z;
    prod_q[9]  <= mid_i.t_x * mid_i.q_y;
    prod_q[10] <= mid_i.t_y * mid_i.q_x;
    prod_q[11] <= mid_i.t_z * mid_i.q_w;
  end

  always_comb begin
    logic signed [S2_W-1:0] sx, sy, sz;
    sx = -S2_W'(prod_q[0]) + S2_W'(prod_q[1]) - S2_W'(prod_q[2]) + S2_W'(prod_q[3]);
    sy = -S2_W'(prod_q[4]) + S2_W'(prod_q[5]) + S2_W'(prod_q[6]) - S2_W'(prod_q[7]);
    sz = -S2_W'(prod_q[8]) - S2_W'(prod_q[9]) + S2_W'(prod_q[10]) + S2_W'(prod_q[11]);
    rot_d.valid = valid_c_q;
    rot_d.r_x   = round_shift2(sx);
    rot_d.r_y   = round_shift2(sy);
    rot_d.r_z   = round_shift2(sz);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q <= '0;
    end else begin
      rot_q <= rot_d;
    end
  end

  assign rot_o = rot_q;

endmodule
`default_nettype wire

>>> rtl/core/quaternion_vector_rotate_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_core
// Rotates a 16-bit vector by a Q2.14 quaternion, v' = q * (0,v) * conj(q).
// ----------------------------------------------------------------------------
// A transaction is taken every cycle: busy_o never rises, and each accepted
// start_i gives one result on result_o, marked by done_o for a single cycle.
// The receiver cannot hold results off, so each result must be taken in the
// cycle that done_o marks. The five register stages are the two multiply
// stages (twelve 16x16 products, then twelve t*q products), each followed
// by its sum-and-round stage, and the saturation register that drives the
// outputs. The quaternion is not normalized; components that overflow 16
// bits are clamped and flagged in clipped.
module quaternion_vector_rotate_core import qvr_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    start_i,
  output logic         busy_o,
  input  wire qvr_in_t data_i,
  output logic         done_o,
  output qvr_out_t     result_o
);

  qvr_mid_t mid;
  qvr_rot_t rot;
  qvr_out_t res_d, res_q;
  logic     done_q;

  assign busy_o = 1'b0;

  qvr_left u_left (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i),
    .data_i  (data_i),
    .mid_o   (mid)
  );

  qvr_right u_right (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .mid_i  (mid),
    .rot_o  (rot)
  );

  function automatic logic fits16(logic signed [R_W-1:0] r);
    return (&r[R_W-1:DATA_W-1]) | ~(|r[R_W-1:DATA_W-1]);
  endfunction

  function automatic logic signed [DATA_W-1:0] sat16(logic signed [R_W-1:0] r);
    logic signed [DATA_W-1:0] s;
    if (fits16(r)) begin
      s = r[DATA_W-1:0];
    end else if (r[R_W-1]) begin
      s = SAT_MIN;
    end else begin
      s = SAT_MAX;
    end
    return s;
  endfunction

  always_comb begin
    res_d.rot_x   = sat16(rot.r_x);
    res_d.rot_y   = sat16(rot.r_y);
    res_d.rot_z   = sat16(rot.r_z);
    res_d.clipped = ~(fits16(rot.r_x) & fits16(rot.r_y) & fits16(rot.r_z));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= rot.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  // every result traces back to an earlier accepted transaction
  a_done_has_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, 5))
    else $error("result without matching transaction");

  // a clipped result holds at least one component at a rail
  a_clip_at_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.clipped) |->
      (result_o.rot_x == SAT_MAX || result_o.rot_x == SAT_MIN ||
       result_o.rot_y == SAT_MAX || result_o.rot_y == SAT_MIN ||
       result_o.rot_z == SAT_MAX || result_o.rot_z == SAT_MIN))
    else $error("clipped flag without saturated component");

  // the flag is registered with the pipeline valid, never on its own
  a_valid_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rot.valid |=> done_o)
    else $error("result strobe lost");

endmodule
`default_nettype wire
